// ----- hw/rtl/window_median_filter_macros.svh -----
// assertion macros for the window median filter checker
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication under reset
`define WMF_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define WMF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/wmf_pkg.sv -----
// shared types and constants of the window median filter
package wmf_pkg;

    localparam int WMF_MAX_ROWS   = 256;
    localparam int WMF_MAX_COLS   = 256;
    localparam int WMF_MAX_RADIUS = 3;

    // signed coordinate width, covers frame sizes up to 4096 plus the window reach
    localparam int WMF_CW = 14;

    localparam logic [1:0] REG_FRAME_ROWS    = 2'd0;
    localparam logic [1:0] REG_FRAME_COLS    = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;
    localparam logic [1:0] REG_BORDER_MODE   = 2'd3;

    localparam logic [1:0] BM_ZERO   = 2'd0;
    localparam logic [1:0] BM_MIRROR = 2'd1;
    localparam logic [1:0] BM_ADJUST = 2'd2;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        TAP_READ,
        TAP_ZERO,
        TAP_SKIP
    } t_tap_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_SELECT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_sort_ctrl;

endpackage

// ----- hw/rtl/wmf_store.sv -----
// frame memory, one synchronous write port and one registered read port
module wmf_store #(
    parameter int MAX_ROWS = wmf_pkg::WMF_MAX_ROWS,
    parameter int MAX_COLS = wmf_pkg::WMF_MAX_COLS,
    parameter int AW       = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [7:0]    i_wrow,
    input  logic [7:0]    i_wcol,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    import wmf_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;

    logic [23:0]      mem [DEPTH];
    logic [23:0]      r_rdata;
    logic [AW+15:0]   waddr_full;
    logic             w_ok;

    assign waddr_full = (AW+16)'(i_wrow) * (AW+16)'(MAX_COLS) + (AW+16)'(i_wcol);
    assign w_ok       = (32'(i_wrow) < 32'(MAX_ROWS)) && (32'(i_wcol) < 32'(MAX_COLS));

    always_ff @(posedge i_clk) begin
        if (i_we && w_ok) begin
            mem[waddr_full[AW-1:0]] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/wmf_tapgen.sv -----
// window tap coordinate, border handling and memory address
module wmf_tapgen #(
    parameter int MAX_COLS = wmf_pkg::WMF_MAX_COLS,
    parameter int AW       = 16
) (
    input  logic [7:0]                   i_row,
    input  logic [7:0]                   i_col,
    input  logic [2:0]                   i_dx,
    input  logic [2:0]                   i_dy,
    input  logic [1:0]                   i_radius,
    input  logic [wmf_pkg::WMF_CW-1:0]   i_rows,
    input  logic [wmf_pkg::WMF_CW-1:0]   i_cols,
    input  logic [1:0]                   i_mode,
    output wmf_pkg::t_tap_kind           o_kind,
    output logic [AW-1:0]                o_addr
);
    import wmf_pkg::*;

    localparam int CW = WMF_CW;

    function automatic logic signed [CW-1:0] mirror(
        input logic signed [CW-1:0] t,
        input logic signed [CW-1:0] len
    );
        logic signed [CW-1:0] m;
        logic signed [CW-1:0] lm1;
        begin
            lm1 = len - CW'(1);
            m   = t;
            if (t < 0) begin
                m = -t;
            end else if (t > lm1) begin
                m = lm1 + lm1 - t;
            end
            if (m < 0) begin
                m = '0;
            end
            if (m > lm1) begin
                m = lm1;
            end
            return m;
        end
    endfunction

    logic signed [CW-1:0] tr, tc, rows_s, cols_s, tr_m, tc_m;
    logic                 in_frame;
    logic [AW+CW-1:0]     addr_full;

    always_comb begin
        rows_s = $signed(i_rows);
        cols_s = $signed(i_cols);
        tr = $signed(CW'(i_row)) + $signed(CW'(i_dx)) - $signed(CW'(i_radius));
        tc = $signed(CW'(i_col)) + $signed(CW'(i_dy)) - $signed(CW'(i_radius));
        in_frame = (tr >= 0) && (tr < rows_s) && (tc >= 0) && (tc < cols_s);
        tr_m = tr;
        tc_m = tc;
        unique case (i_mode)
            BM_MIRROR: begin
                tr_m   = mirror(tr, rows_s);
                tc_m   = mirror(tc, cols_s);
                o_kind = TAP_READ;
            end
            BM_ADJUST: begin
                o_kind = in_frame ? TAP_READ : TAP_SKIP;
            end
            default: begin
                o_kind = in_frame ? TAP_READ : TAP_ZERO;
            end
        endcase
        addr_full = (AW+CW)'(unsigned'(tr_m)) * (AW+CW)'(MAX_COLS)
                  + (AW+CW)'(unsigned'(tc_m));
        o_addr = addr_full[AW-1:0];
    end
endmodule

// ----- hw/rtl/wmf_sorter.sv -----
// insertion sorter for one channel, shifts out toward the median
module wmf_sorter #(
    parameter int DEPTH = 49
) (
    input  logic                i_clk,
    input  wmf_pkg::t_sort_ctrl i_ctrl,
    input  logic                i_ins,
    input  logic [7:0]          i_val,
    output logic [7:0]          o_head
);
    import wmf_pkg::*;

    // ninth bit marks an empty slot that sorts above every sample
    logic [8:0] r_s [DEPTH];
    logic [8:0] v;

    assign v = {1'b0, i_val};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_s[i] <= 9'h100;
            end
        end else if (i_ins) begin
            if (r_s[0] > v) begin
                r_s[0] <= v;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (r_s[i] > v) begin
                    r_s[i] <= (r_s[i-1] <= v) ? v : r_s[i-1];
                end
            end
        end else if (i_ctrl.shift) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[DEPTH-1] <= 9'h100;
        end
    end

    assign o_head = r_s[0][8] ? 8'd0 : r_s[0][7:0];
endmodule

// ----- hw/rtl/window_median_filter.sv -----
// top level of the window median filter
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_ready  | i_cmd, i_pixel_row/col, i_red/green/blue_in
//  result   | o_valid / i_ready  | o_red_median, o_green_median, o_blue_median
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  a write is stored in the frame memory at the transfer edge
//  a compute takes a transfer, (2r+1)^2 tap reads one per cycle through
//  the memory read port, a pipeline drain, sorter shifts down to the median,
//  a step to pick the median and a step to load the result
//  the frame memory is not cleared by reset; config resets to 256, 256, 2, 0
//  a compute waits in its last step while an earlier result is not taken
module window_median_filter #(
    parameter int MAX_ROWS   = wmf_pkg::WMF_MAX_ROWS,
    parameter int MAX_COLS   = wmf_pkg::WMF_MAX_COLS,
    parameter int MAX_RADIUS = wmf_pkg::WMF_MAX_RADIUS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_pixel_row,
    input  logic [7:0] i_pixel_col,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red_median,
    output logic [7:0] o_green_median,
    output logic [7:0] o_blue_median,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import wmf_pkg::*;

    localparam int CW    = WMF_CW;
    localparam int AW    = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
    localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW    = $clog2(WIN + 1);

    t_state      r_state, n_state;
    logic [8:0]  r_frame_rows, r_frame_cols;
    logic [1:0]  r_radius, r_mode;
    logic [7:0]  r_row, r_col;
    logic [2:0]  r_dx, r_dy;
    logic [NW-1:0] r_cnt, r_sel;
    logic        r_p1_valid, r_p2_valid;
    t_tap_kind   r_p1_kind, r_p2_kind;
    logic [AW-1:0] r_p1_addr;
    logic        r_o_valid;
    logic [7:0]  r_o_red, r_o_green, r_o_blue;

    logic [CW-1:0] rows_eff, cols_eff;
    logic [1:0]  rad_eff;
    logic [2:0]  span;
    t_tap_kind   tap_kind;
    logic [AW-1:0] tap_addr;
    logic [23:0] rdata;
    logic        in_xfer, issue, last_tap, load, ins;
    t_sort_ctrl  sort_ctrl;
    logic [7:0]  head_r, head_g, head_b;

    assign in_xfer = i_valid && o_ready;

    always_comb begin
        rows_eff = (r_frame_rows == 9'd0) ? CW'(1) :
                   (CW'(r_frame_rows) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(r_frame_rows);
        cols_eff = (r_frame_cols == 9'd0) ? CW'(1) :
                   (CW'(r_frame_cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_frame_cols);
        rad_eff  = (r_radius > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : r_radius;
        span     = {rad_eff, 1'b0};
        last_tap = (r_dx == span) && (r_dy == span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= 9'd256;
            r_frame_cols <= 9'd256;
            r_radius     <= 2'd2;
            r_mode       <= BM_ZERO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_ROWS:    r_frame_rows <= i_cfg_data;
                REG_FRAME_COLS:    r_frame_cols <= i_cfg_data;
                REG_WINDOW_RADIUS: r_radius     <= i_cfg_data[1:0];
                REG_BORDER_MODE:   r_mode       <= i_cfg_data[1:0];
            endcase
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        issue           = 1'b0;
        load            = 1'b0;
        sort_ctrl.clear = 1'b0;
        sort_ctrl.shift = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_cmd == CMD_COMPUTE) begin
                    sort_ctrl.clear = 1'b1;
                    n_state         = ST_GATHER;
                end
            end
            ST_GATHER: begin
                issue = 1'b1;
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid) begin
                    n_state = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (r_sel == (r_cnt >> 1)) begin
                    n_state = ST_DONE;
                end else begin
                    sort_ctrl.shift = 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign ins = r_p2_valid && (r_p2_kind != TAP_SKIP);

    always_ff @(posedge i_clk) begin
        r_p1_kind <= tap_kind;
        r_p1_addr <= tap_addr;
        r_p2_kind <= r_p1_kind;
        if (in_xfer) begin
            r_row <= i_pixel_row;
            r_col <= i_pixel_col;
            r_dx  <= 3'd0;
            r_dy  <= 3'd0;
            r_cnt <= '0;
            r_sel <= '0;
        end else begin
            if (issue) begin
                if (r_dy == span) begin
                    r_dy <= 3'd0;
                    r_dx <= r_dx + 3'd1;
                end else begin
                    r_dy <= r_dy + 3'd1;
                end
            end
            if (ins) begin
                r_cnt <= r_cnt + NW'(1);
            end
            if (sort_ctrl.shift) begin
                r_sel <= r_sel + NW'(1);
            end
        end
        if (load) begin
            r_o_red   <= head_r;
            r_o_green <= head_g;
            r_o_blue  <= head_b;
        end
    end

    wmf_tapgen #(.MAX_COLS(MAX_COLS), .AW(AW)) u_tapgen (
        .i_row    (r_row),
        .i_col    (r_col),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .i_radius (rad_eff),
        .i_rows   (rows_eff),
        .i_cols   (cols_eff),
        .i_mode   (r_mode),
        .o_kind   (tap_kind),
        .o_addr   (tap_addr)
    );

    wmf_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_cmd == CMD_WRITE),
        .i_wrow  (i_pixel_row),
        .i_wcol  (i_pixel_col),
        .i_wdata ({i_blue_in, i_green_in, i_red_in}),
        .i_re    (r_p1_valid),
        .i_raddr (r_p1_addr),
        .o_rdata (rdata)
    );

    wmf_sorter #(.DEPTH(WIN)) u_sort_r (
        .i_clk  (i_clk),
        .i_ctrl (sort_ctrl),
        .i_ins  (ins),
        .i_val  ((r_p2_kind == TAP_READ) ? rdata[7:0] : 8'd0),
        .o_head (head_r)
    );

    wmf_sorter #(.DEPTH(WIN)) u_sort_g (
        .i_clk  (i_clk),
        .i_ctrl (sort_ctrl),
        .i_ins  (ins),
        .i_val  ((r_p2_kind == TAP_READ) ? rdata[15:8] : 8'd0),
        .o_head (head_g)
    );

    wmf_sorter #(.DEPTH(WIN)) u_sort_b (
        .i_clk  (i_clk),
        .i_ctrl (sort_ctrl),
        .i_ins  (ins),
        .i_val  ((r_p2_kind == TAP_READ) ? rdata[23:16] : 8'd0),
        .o_head (head_b)
    );

    assign o_valid        = r_o_valid;
    assign o_red_median   = r_o_red;
    assign o_green_median = r_o_green;
    assign o_blue_median  = r_o_blue;
endmodule

// ----- hw/rtl/wmf_checker.sv -----
// port-level checker for the window median filter, bound to the top level
`include "window_median_filter_macros.svh"

module wmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_cmd,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red_median,
    input logic [7:0] o_green_median,
    input logic [7:0] o_blue_median
);
    import wmf_pkg::*;

    logic [23:0] result_bus;

    assign result_bus = {o_red_median, o_green_median, o_blue_median};

    // stalled result holds
    `WMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(result_bus))
    // a write transfer never makes a result
    `WMF_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_valid && o_ready && i_cmd == CMD_WRITE && !o_valid, !o_valid)
    // a compute transfer makes the block busy
    `WMF_ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, i_valid && o_ready && i_cmd == CMD_COMPUTE, !o_ready)
endmodule

bind window_median_filter wmf_checker u_wmf_checker (.*);

// ----- test/tb.sv -----
// testbench for the window median filter: directed table, then random phases
`timescale 1ns / 100ps

module tb;
    import wmf_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 50;

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_idx;
        logic [8:0] cfg_val;
        logic       cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
        logic [23:0] want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_cmd = 1'b0;
    logic [7:0] i_pixel_row = '0;
    logic [7:0] i_pixel_col = '0;
    logic [7:0] i_red_in = '0;
    logic [7:0] i_green_in = '0;
    logic [7:0] i_blue_in = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_red_median;
    logic [7:0] o_green_median;
    logic [7:0] o_blue_median;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data = '0;

    logic [23:0] pixel_mem [65536];
    logic [8:0]  sh_rows;
    logic [8:0]  sh_cols;
    logic [1:0]  sh_radius;
    logic [1:0]  sh_mode;
    logic [23:0] medians_due [$];
    t_row        steps [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;

    window_median_filter dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // result side
    always @(posedge i_clk) begin
        logic [23:0] w;
        if (i_rst_n && o_valid && i_ready) begin
            if (medians_due.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                w = medians_due.pop_front();
                if (o_red_median !== w[23:16])
                    report_mismatch($sformatf("red %h want %h", o_red_median, w[23:16]));
                if (o_green_median !== w[15:8])
                    report_mismatch($sformatf("green %h want %h", o_green_median, w[15:8]));
                if (o_blue_median !== w[7:0])
                    report_mismatch($sformatf("blue %h want %h", o_blue_median, w[7:0]));
            end
        end
        i_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
    end

    function automatic int clamp_len(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic int fold_coord(int t, int len);
        if (t < 0) t = -t;
        else if (t > len - 1) t = 2 * (len - 1) - t;
        if (t < 0) t = 0;
        if (t > len - 1) t = len - 1;
        return t;
    endfunction

    function automatic logic [23:0] predict_median(int row, int col);
        int rows, cols, r, n, tr, tc, i, j, ch;
        bit ins;
        int taps [3][49];
        int x;
        logic [23:0] px;
        logic [23:0] res;
        rows = clamp_len(sh_rows);
        cols = clamp_len(sh_cols);
        r = int'(sh_radius);
        n = 0;
        for (int dx = -r; dx <= r; dx++) begin
            for (int dy = -r; dy <= r; dy++) begin
                tr = row + dx;
                tc = col + dy;
                ins = tr >= 0 && tr < rows && tc >= 0 && tc < cols;
                if (sh_mode == BM_MIRROR) begin
                    tr = fold_coord(tr, rows);
                    tc = fold_coord(tc, cols);
                    ins = 1'b1;
                end else if (sh_mode == BM_ADJUST && !ins) begin
                    continue;
                end
                px = ins ? pixel_mem[tr * 256 + tc] : 24'h0;
                taps[0][n] = px[23:16];
                taps[1][n] = px[15:8];
                taps[2][n] = px[7:0];
                n++;
            end
        end
        res = '0;
        if (n == 0) return res;
        for (ch = 0; ch < 3; ch++) begin
            for (i = 1; i < n; i++) begin
                x = taps[ch][i];
                j = i - 1;
                while (j >= 0 && taps[ch][j] > x) begin
                    taps[ch][j + 1] = taps[ch][j];
                    j--;
                end
                taps[ch][j + 1] = x;
            end
            res[23 - 8 * ch -: 8] = taps[ch][n / 2];
        end
        return res;
    endfunction

    task automatic send_pixel(logic cmd, logic [7:0] row, logic [7:0] col,
                              logic [7:0] rv, logic [7:0] gv, logic [7:0] bv,
                              bit typed, logic [23:0] tv);
        if (!quiet) begin
            while ($urandom_range(99) < 22) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_pixel_row <= row;
        i_pixel_col <= col;
        i_red_in    <= rv;
        i_green_in  <= gv;
        i_blue_in   <= bv;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == CMD_WRITE)
            pixel_mem[int'(row) * 256 + int'(col)] = {rv, gv, bv};
        else
            medians_due.push_back(typed ? tv : predict_median(row, col));
    endtask

    task automatic fill_block(int r0, int r1, int c0, int c1);
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                send_pixel(CMD_WRITE, 8'(r), 8'(c), 8'($urandom), 8'($urandom),
                           8'($urandom), 1'b0, '0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        i_valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_ROWS:    sh_rows = val;
            REG_FRAME_COLS:    sh_cols = val;
            REG_WINDOW_RADIUS: sh_radius = val[1:0];
            default:           sh_mode = val[1:0];
        endcase
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [8:0] val);
        t_row s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        steps.push_back(s);
    endtask

    task automatic add_item(logic cmd, logic [7:0] row, logic [7:0] col,
                            logic [23:0] px, bit typed, logic [23:0] want);
        t_row s;
        s = '{default: '0};
        s.cmd = cmd;
        s.row = row;
        s.col = col;
        {s.red, s.green, s.blue} = px;
        s.typed = typed;
        s.want = want;
        steps.push_back(s);
    endtask

    // random frames stay inside the filled corner
    task automatic random_cfg(int p);
        logic [8:0] rv, cv;
        case ($urandom_range(3))
            0: rv = 9'd1;
            1: rv = 9'd16;
            2: rv = 9'd0;
            default: rv = 9'($urandom_range(2, 15));
        endcase
        case ($urandom_range(3))
            0: cv = 9'd1;
            1: cv = 9'd16;
            2: cv = 9'd0;
            default: cv = 9'($urandom_range(2, 15));
        endcase
        if (p == 0) begin
            rv = 9'd16;
            cv = 9'd16;
        end else if (p == 1) begin
            rv = 9'd1;
            cv = 9'd1;
        end
        write_reg(REG_FRAME_ROWS, rv);
        write_reg(REG_FRAME_COLS, cv);
        write_reg(REG_WINDOW_RADIUS, p == 0 ? 9'd3 : p == 1 ? 9'd0 : 9'($urandom_range(3)));
        write_reg(REG_BORDER_MODE, p == 0 ? 9'(BM_ADJUST) : p == 1 ? 9'(BM_MIRROR)
                                          : 9'($urandom_range(3)));
    endtask

    initial begin
        int rows, cols;
        logic [7:0] rr, cc;
        sh_rows = 9'd256;
        sh_cols = 9'd256;
        sh_radius = 2'd2;
        sh_mode = BM_ZERO;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every entry that a later compute can reach
        quiet = 1'b1;
        fill_block(0, 15, 0, 15);
        fill_block(248, 255, 248, 255);
        fill_block(0, 0, 120, 135);
        fill_block(124, 132, 124, 132);
        quiet = 1'b0;

        add_cfg(REG_WINDOW_RADIUS, 9'd0);
        add_cfg(REG_BORDER_MODE, 9'(BM_ZERO));
        add_cfg(REG_FRAME_ROWS, 9'd1);
        add_cfg(REG_FRAME_COLS, 9'd1);
        add_item(CMD_WRITE, 8'd0, 8'd0, 24'hff0080, 1'b0, '0);
        add_item(CMD_COMPUTE, 8'd0, 8'd0, 24'hffffff, 1'b1, 24'hff0080);
        add_cfg(REG_WINDOW_RADIUS, 9'd1);
        add_item(CMD_COMPUTE, 8'd0, 8'd0, 24'h000000, 1'b1, 24'h000000);
        add_cfg(REG_WINDOW_RADIUS, 9'd3);
        add_cfg(REG_BORDER_MODE, 9'(BM_ADJUST));
        add_item(CMD_COMPUTE, 8'd200, 8'd200, 24'h5a5a5a, 1'b1, 24'h000000);
        add_item(CMD_COMPUTE, 8'd0, 8'd0, 24'ha5a5a5, 1'b1, 24'hff0080);
        add_cfg(REG_BORDER_MODE, 9'd3);
        add_item(CMD_COMPUTE, 8'd0, 8'd0, 24'h000000, 1'b1, 24'h000000);
        add_cfg(REG_BORDER_MODE, 9'(BM_MIRROR));
        add_cfg(REG_FRAME_ROWS, 9'd256);
        add_cfg(REG_FRAME_COLS, 9'd256);
        add_item(CMD_COMPUTE, 8'd0, 8'd0, 24'h000000, 1'b0, '0);
        add_item(CMD_WRITE, 8'd255, 8'd255, 24'hffffff, 1'b0, '0);
        add_item(CMD_COMPUTE, 8'd255, 8'd255, 24'hffffff, 1'b0, '0);
        add_cfg(REG_FRAME_ROWS, 9'd0);
        add_cfg(REG_FRAME_COLS, 9'd511);
        add_cfg(REG_BORDER_MODE, 9'(BM_ADJUST));
        add_item(CMD_COMPUTE, 8'd0, 8'd128, 24'h000000, 1'b0, '0);
        add_item(CMD_COMPUTE, 8'd5, 8'd255, 24'h000000, 1'b0, '0);
        add_cfg(REG_FRAME_ROWS, 9'd256);
        add_cfg(REG_BORDER_MODE, 9'(BM_ZERO));
        add_item(CMD_COMPUTE, 8'd128, 8'd128, 24'hffffff, 1'b0, '0);

        foreach (steps[i]) begin
            if (steps[i].is_cfg)
                write_reg(steps[i].cfg_idx, steps[i].cfg_val);
            else
                send_pixel(steps[i].cmd, steps[i].row, steps[i].col, steps[i].red,
                           steps[i].green, steps[i].blue, steps[i].typed, steps[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            random_cfg(p);
            quiet = (p == 4);
            rows = clamp_len(sh_rows);
            cols = clamp_len(sh_cols);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9) < 8) begin
                    rr = 8'($urandom_range(0, rows + 3 > 255 ? 255 : rows + 3));
                    cc = 8'($urandom_range(0, cols + 3 > 255 ? 255 : cols + 3));
                end else begin
                    rr = 8'($urandom);
                    cc = 8'($urandom);
                end
                send_pixel($urandom_range(1) ? CMD_COMPUTE : CMD_WRITE, rr, cc,
                           8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        i_valid <= 1'b0;
        while (medians_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
